### sv/rrab_pkg.sv
// Shared types and constants for the rounded rectangle alpha blend core.
// Used by the design modules and the testbench; no dependencies of its own.
package rrab_pkg;

  localparam int DIM_W  = 12;   // rectangle and screen sizes
  localparam int RAD_W  = 11;   // corner radius
  localparam int SCR_W  = 13;   // signed screen coordinates
  localparam int PIX_W  = 32;
  localparam int CHAN_W = 8;
  localparam int SQ_W   = 2 * RAD_W;
  localparam int PROD_W = 2 * CHAN_W;

  localparam logic [CHAN_W-1:0] CHAN_MAX   = 8'd255;
  localparam logic [PIX_W-1:0]  FULL_ALPHA = 32'hFF00_0000;

  localparam logic [DIM_W-1:0]  RST_RECT_W  = 12'd0;
  localparam logic [DIM_W-1:0]  RST_RECT_H  = 12'd0;
  localparam logic [RAD_W-1:0]  RST_RADIUS  = 11'd0;
  localparam logic [PIX_W-1:0]  RST_FILL    = 32'd0;
  localparam logic [CHAN_W-1:0] RST_ALPHA   = 8'd255;
  localparam logic [DIM_W-1:0]  RST_SCR_W   = 12'd1024;
  localparam logic [DIM_W-1:0]  RST_SCR_H   = 12'd768;

  typedef enum logic [2:0] {
    REG_RECT_WIDTH    = 3'd0,
    REG_RECT_HEIGHT   = 3'd1,
    REG_CORNER_RADIUS = 3'd2,
    REG_FILL_COLOR    = 3'd3,
    REG_BLEND_ALPHA   = 3'd4,
    REG_SCREEN_WIDTH  = 3'd5,
    REG_SCREEN_HEIGHT = 3'd6
  } cfg_reg_t;

  // Load enables of the three work stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } adv_t;

endpackage

### sv/rrab_mask.sv
// Clip and rounded-corner mask pipeline: three register stages.
// Depends on rrab_pkg.
module rrab_mask #(
  parameter int COORD_BITS = 11
) (
  input  logic                      clk,
  input  rrab_pkg::adv_t            adv,
  input  logic [rrab_pkg::SCR_W-1:0] screen_x,
  input  logic [rrab_pkg::SCR_W-1:0] screen_y,
  input  logic [COORD_BITS-1:0]     local_x,
  input  logic [COORD_BITS-1:0]     local_y,
  input  logic [rrab_pkg::DIM_W-1:0] rect_w,
  input  logic [rrab_pkg::DIM_W-1:0] rect_h,
  input  logic [rrab_pkg::RAD_W-1:0] radius,
  input  logic [rrab_pkg::DIM_W-1:0] scr_w,
  input  logic [rrab_pkg::DIM_W-1:0] scr_h,
  output logic                      write_ok
);

  localparam int GW = ((COORD_BITS > rrab_pkg::DIM_W) ? COORD_BITS : rrab_pkg::DIM_W) + 2;

  logic [GW-1:0] lx_e, ly_e, w_e, h_e, r_e, wr_e, hr_e;
  logic          left, top, right, bottom, c0, c1, c2, c3;
  logic          base_ok, on_screen;
  logic [GW-1:0] dx_full, dy_full;

  logic                         base_ok_r, corner_r;
  logic [rrab_pkg::RAD_W-1:0]   dx_r, dy_r;
  logic                         base_ok2_r, corner2_r;
  logic [rrab_pkg::SQ_W:0]      dist_r;
  logic [rrab_pkg::SQ_W-1:0]    rsq_r;
  logic                         write_ok_r;

  always_comb begin
    lx_e = GW'(local_x);
    ly_e = GW'(local_y);
    w_e  = GW'(rect_w);
    h_e  = GW'(rect_h);
    r_e  = GW'(radius);
    wr_e = w_e - r_e;
    hr_e = h_e - r_e;
    left   = lx_e < r_e;
    top    = ly_e < r_e;
    right  = $signed(lx_e) >= $signed(wr_e);
    bottom = $signed(ly_e) >= $signed(hr_e);
    c0 = left && top;
    c1 = right && top;
    c2 = left && bottom;
    c3 = right && bottom;
    // Corner order decides: left side only when the top-left or bottom-left box wins
    dx_full = (c0 || (c2 && !c1)) ? (r_e - GW'(1) - lx_e) : (lx_e - wr_e);
    dy_full = (c0 || c1) ? (r_e - GW'(1) - ly_e) : (ly_e - hr_e);
    on_screen = !screen_x[rrab_pkg::SCR_W-1] && !screen_y[rrab_pkg::SCR_W-1] &&
                (screen_x[rrab_pkg::DIM_W-1:0] < scr_w) &&
                (screen_y[rrab_pkg::DIM_W-1:0] < scr_h);
    base_ok = (rect_w != '0) && (rect_h != '0) && on_screen &&
              (lx_e < w_e) && (ly_e < h_e);
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      base_ok_r <= base_ok;
      corner_r  <= (radius != '0) && (c0 || c1 || c2 || c3);
      dx_r      <= dx_full[rrab_pkg::RAD_W-1:0];
      dy_r      <= dy_full[rrab_pkg::RAD_W-1:0];
    end
    if (adv.s2) begin
      base_ok2_r <= base_ok_r;
      corner2_r  <= corner_r;
      dist_r     <= (rrab_pkg::SQ_W+1)'(dx_r * dx_r) + (rrab_pkg::SQ_W+1)'(dy_r * dy_r);
      rsq_r      <= rrab_pkg::SQ_W'(radius * radius);
    end
    if (adv.s3) begin
      write_ok_r <= base_ok2_r && (!corner2_r || (dist_r <= (rrab_pkg::SQ_W+1)'(rsq_r)));
    end
  end

  assign write_ok = write_ok_r;

endmodule

### sv/rrab_blend.sv
// Per-channel alpha blend pipeline: products, divide by 255, final select.
// Depends on rrab_pkg.
module rrab_blend (
  input  logic                        clk,
  input  rrab_pkg::adv_t              adv,
  input  logic [rrab_pkg::PIX_W-1:0]  dest_pixel,
  input  logic [rrab_pkg::PIX_W-1:0]  fill_color,
  input  logic [rrab_pkg::CHAN_W-1:0] alpha,
  output logic [rrab_pkg::PIX_W-1:0]  dest_out,
  output logic [rrab_pkg::PIX_W-1:0]  blend_out
);

  localparam int CW = rrab_pkg::CHAN_W;
  localparam int PW = rrab_pkg::PROD_W;

  logic [CW-1:0]  inv_a;
  logic [PW-1:0]  sum   [3];
  logic [PW-1:0]  sum_r [3];
  logic [PW-1:0]  quo_t [3];
  logic [CW-1:0]  quo_r [3];
  logic [rrab_pkg::PIX_W-1:0] dst1_r, dst2_r, dst3_r, mixed, blend_r;

  assign inv_a = rrab_pkg::CHAN_MAX - alpha;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c] = PW'(fill_color[c*CW +: CW] * alpha) + PW'(dest_pixel[c*CW +: CW] * inv_a);
      // Exact x/255 for x up to 255*255
      quo_t[c] = sum_r[c] + PW'(sum_r[c] >> CW) + PW'(1);
    end
    mixed = rrab_pkg::FULL_ALPHA | {8'd0, quo_r[2], quo_r[1], quo_r[0]};
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      for (int c = 0; c < 3; c++) sum_r[c] <= sum[c];
      dst1_r <= dest_pixel;
    end
    if (adv.s2) begin
      for (int c = 0; c < 3; c++) quo_r[c] <= quo_t[c][PW-1:CW];
      dst2_r <= dst1_r;
    end
    if (adv.s3) begin
      dst3_r <= dst2_r;
      if (alpha == rrab_pkg::CHAN_MAX) begin
        blend_r <= fill_color;
      end else if (alpha == '0) begin
        blend_r <= dst2_r;
      end else begin
        blend_r <= mixed;
      end
    end
  end

  assign dest_out  = dst3_r;
  assign blend_out = blend_r;

endmodule

### sv/rounded_rect_alpha_blend_core.sv
// Rounded rectangle alpha blend core: top level with config registers,
// stage control and output register. Depends on rrab_pkg, rrab_mask, rrab_blend.
// Each input transaction runs through three work stages and the output register to out_tvalid.
// Throughput: one pixel per cycle while out_tready does not stall the output.
// A stalled output holds the pipeline; in_tready stays high while any stage has a bubble.
// Reset (rst_n low, synchronous) empties the pipeline and loads register reset values.
module rounded_rect_alpha_blend_core #(
  parameter int COORD_BITS = 11
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // screen_x[12:0], screen_y[12:0], local_x, local_y, dest_pixel[31:0], zero fill
  input  logic [((2*rrab_pkg::SCR_W + 2*COORD_BITS + rrab_pkg::PIX_W + 7) / 8) * 8 - 1:0]
                               in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata,   // new_pixel[31:0]
  output logic [0:0]           out_tuser,   // write_pixel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int SW  = rrab_pkg::SCR_W;
  localparam int LX0 = 2 * SW;
  localparam int LY0 = LX0 + COORD_BITS;
  localparam int DP0 = LY0 + COORD_BITS;

  logic [rrab_pkg::DIM_W-1:0]  rect_w_r, rect_h_r, scr_w_r, scr_h_r;
  logic [rrab_pkg::RAD_W-1:0]  radius_r;
  logic [rrab_pkg::PIX_W-1:0]  fill_r;
  logic [rrab_pkg::CHAN_W-1:0] alpha_r;

  logic           v1_r, v2_r, v3_r, out_valid_r;
  logic           ld_out;
  rrab_pkg::adv_t adv;
  logic           write_ok;
  logic [rrab_pkg::PIX_W-1:0] dest_out, blend_out, pixel_r;
  logic           wpix_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rect_w_r <= rrab_pkg::RST_RECT_W;
      rect_h_r <= rrab_pkg::RST_RECT_H;
      radius_r <= rrab_pkg::RST_RADIUS;
      fill_r   <= rrab_pkg::RST_FILL;
      alpha_r  <= rrab_pkg::RST_ALPHA;
      scr_w_r  <= rrab_pkg::RST_SCR_W;
      scr_h_r  <= rrab_pkg::RST_SCR_H;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rrab_pkg::REG_RECT_WIDTH:    rect_w_r <= cfg_data[rrab_pkg::DIM_W-1:0];
        rrab_pkg::REG_RECT_HEIGHT:   rect_h_r <= cfg_data[rrab_pkg::DIM_W-1:0];
        rrab_pkg::REG_CORNER_RADIUS: radius_r <= cfg_data[rrab_pkg::RAD_W-1:0];
        rrab_pkg::REG_FILL_COLOR:    fill_r   <= cfg_data;
        rrab_pkg::REG_BLEND_ALPHA:   alpha_r  <= cfg_data[rrab_pkg::CHAN_W-1:0];
        rrab_pkg::REG_SCREEN_WIDTH:  scr_w_r  <= cfg_data[rrab_pkg::DIM_W-1:0];
        rrab_pkg::REG_SCREEN_HEIGHT: scr_h_r  <= cfg_data[rrab_pkg::DIM_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Each stage loads when it is empty or the stage after it loads
  always_comb begin
    ld_out    = !out_valid_r || out_tready;
    adv.s3    = !v3_r || ld_out;
    adv.s2    = !v2_r || adv.s3;
    adv.s1    = !v1_r || adv.s2;
    in_tready = adv.s1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv.s1) v1_r <= in_tvalid;
      if (adv.s2) v2_r <= v1_r;
      if (adv.s3) v3_r <= v2_r;
      if (ld_out) out_valid_r <= v3_r;
    end
  end

  rrab_mask #(.COORD_BITS(COORD_BITS)) u_mask (
    .clk      (clk),
    .adv      (adv),
    .screen_x (in_tdata[SW-1:0]),
    .screen_y (in_tdata[2*SW-1:SW]),
    .local_x  (in_tdata[LX0 +: COORD_BITS]),
    .local_y  (in_tdata[LY0 +: COORD_BITS]),
    .rect_w   (rect_w_r),
    .rect_h   (rect_h_r),
    .radius   (radius_r),
    .scr_w    (scr_w_r),
    .scr_h    (scr_h_r),
    .write_ok (write_ok)
  );

  rrab_blend u_blend (
    .clk        (clk),
    .adv        (adv),
    .dest_pixel (in_tdata[DP0 +: rrab_pkg::PIX_W]),
    .fill_color (fill_r),
    .alpha      (alpha_r),
    .dest_out   (dest_out),
    .blend_out  (blend_out)
  );

  always_ff @(posedge clk) begin
    if (ld_out) begin
      pixel_r <= write_ok ? blend_out : dest_out;
      wpix_r  <= write_ok;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = pixel_r;
  assign out_tuser[0] = wpix_r;

endmodule

### sv/rrab_checker.sv
// Port-level checks for the rounded rectangle alpha blend core, bound to the top level.
// Depends only on the top level's port list.
module rrab_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [0:0]  out_tuser
);

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // An empty output register never blocks input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

endmodule

bind rounded_rect_alpha_blend_core rrab_checker u_rrab_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

### dv/tb_top.sv
// Self-checking testbench for rounded_rect_alpha_blend_core: corner mask, clipping and blending.
// Holds its own pixel predictor and register copy, drives random stalls on both streams.
// Depends on rrab_pkg and the core RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_BITS     = 11;
  localparam int IN_W           =
    ((2 * rrab_pkg::SCR_W + 2 * COORD_BITS + rrab_pkg::PIX_W + 7) / 8) * 8;
  localparam int LATENCY        = 3;
  localparam int HOLD_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [rrab_pkg::PIX_W-1:0] dest_pixel;
    logic [COORD_BITS-1:0]      local_y;
    logic [COORD_BITS-1:0]      local_x;
    logic [rrab_pkg::SCR_W-1:0] screen_y;
    logic [rrab_pkg::SCR_W-1:0] screen_x;
  } pixel_in_t;

  typedef struct packed {
    logic [rrab_pkg::PIX_W-1:0] new_pixel;
    logic                       write_pixel;
  } pixel_out_t;

  typedef struct {
    logic [rrab_pkg::DIM_W-1:0]  rect_w;
    logic [rrab_pkg::DIM_W-1:0]  rect_h;
    logic [rrab_pkg::RAD_W-1:0]  radius;
    logic [rrab_pkg::PIX_W-1:0]  fill;
    logic [rrab_pkg::CHAN_W-1:0] alpha;
    logic [rrab_pkg::DIM_W-1:0]  scr_w;
    logic [rrab_pkg::DIM_W-1:0]  scr_h;
  } blend_regs_t;

  logic            clk;
  logic            rst_n      = 1'b0;
  logic            in_tvalid  = 1'b0;
  logic            in_tready;
  logic [IN_W-1:0] in_tdata   = '0;
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [31:0]     out_tdata;
  logic [0:0]      out_tuser;
  logic            cfg_valid  = 1'b0;
  logic            cfg_ready;
  logic [2:0]      cfg_index  = '0;
  logic [31:0]     cfg_data   = '0;

  blend_regs_t regs = '{rrab_pkg::RST_RECT_W, rrab_pkg::RST_RECT_H, rrab_pkg::RST_RADIUS,
                        rrab_pkg::RST_FILL, rrab_pkg::RST_ALPHA, rrab_pkg::RST_SCR_W,
                        rrab_pkg::RST_SCR_H};
  pixel_out_t  pending_pixels[$];

  int  src_idle_pct   = 0;
  int  sink_stall_pct = 0;
  bit  hold_request   = 1'b0;
  int  n_errors       = 0;
  int  n_checked      = 0;
  int  n_drawn        = 0;
  int  n_reg_writes   = 0;
  int  idle_cycles    = 0;

  rounded_rect_alpha_blend_core #(.COORD_BITS(COORD_BITS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit in_rounded_mask(longint lx, longint ly, longint w, longint h,
                                         longint rad);
    longint dx, dy;
    if (rad <= 0) return 1'b1;
    // first corner box that holds the pixel decides
    if (lx < rad && ly < rad) begin
      dx = rad - 1 - lx;
      dy = rad - 1 - ly;
    end else if (lx >= w - rad && ly < rad) begin
      dx = lx - (w - rad);
      dy = rad - 1 - ly;
    end else if (lx < rad && ly >= h - rad) begin
      dx = rad - 1 - lx;
      dy = ly - (h - rad);
    end else if (lx >= w - rad && ly >= h - rad) begin
      dx = lx - (w - rad);
      dy = ly - (h - rad);
    end else begin
      return 1'b1;
    end
    return dx * dx + dy * dy <= rad * rad;
  endfunction

  function automatic logic [rrab_pkg::PIX_W-1:0] mix_argb(
      logic [rrab_pkg::PIX_W-1:0] dst, logic [rrab_pkg::PIX_W-1:0] src,
      logic [rrab_pkg::CHAN_W-1:0] a);
    logic [rrab_pkg::PIX_W-1:0] mixed;
    int s, d, av, top;
    av  = int'(a);
    top = int'(rrab_pkg::CHAN_MAX);
    if (a == rrab_pkg::CHAN_MAX) return src;
    if (a == '0) return dst;
    mixed = rrab_pkg::FULL_ALPHA;
    for (int c = 0; c < 3; c++) begin
      s = int'(src[8*c +: 8]);
      d = int'(dst[8*c +: 8]);
      mixed[8*c +: 8] = 8'((s * av + d * (top - av)) / top);
    end
    return mixed;
  endfunction

  function automatic pixel_out_t composite_pixel(pixel_in_t p, blend_regs_t r);
    longint sx, sy, lx, ly, w, h;
    bit hit;
    pixel_out_t o;
    sx  = longint'($signed(p.screen_x));
    sy  = longint'($signed(p.screen_y));
    lx  = longint'(p.local_x);
    ly  = longint'(p.local_y);
    w   = longint'(r.rect_w);
    h   = longint'(r.rect_h);
    hit = (w != 0) && (h != 0) &&
          (sx >= 0) && (sx < longint'(r.scr_w)) &&
          (sy >= 0) && (sy < longint'(r.scr_h)) &&
          (lx < w) && (ly < h);
    if (hit) hit = in_rounded_mask(lx, ly, w, h, longint'(r.radius));
    o.write_pixel = hit;
    o.new_pixel   = hit ? mix_argb(p.dest_pixel, r.fill, r.alpha) : p.dest_pixel;
    return o;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic pixel_in_t mk_pixel(int sx, int sy, int lx, int ly,
                                         logic [rrab_pkg::PIX_W-1:0] dest);
    pixel_in_t p;
    p.screen_x   = rrab_pkg::SCR_W'(sx);
    p.screen_y   = rrab_pkg::SCR_W'(sy);
    p.local_x    = COORD_BITS'(lx);
    p.local_y    = COORD_BITS'(ly);
    p.dest_pixel = dest;
    return p;
  endfunction

  function automatic pixel_in_t rand_pixel();
    pixel_in_t p;
    if ($urandom_range(7) == 0) begin
      p.screen_x   = rrab_pkg::SCR_W'($urandom);
      p.screen_y   = rrab_pkg::SCR_W'($urandom);
      p.local_x    = COORD_BITS'($urandom);
      p.local_y    = COORD_BITS'($urandom);
      p.dest_pixel = $urandom;
      return p;
    end
    // mostly near the visible window and the rectangle, one step past each window edge and the far rectangle edges
    return mk_pixel(int'($urandom_range(regs.scr_w + 1)) - 1,
                    int'($urandom_range(regs.scr_h + 1)) - 1,
                    int'($urandom_range(regs.rect_w)),
                    int'($urandom_range(regs.rect_h)),
                    $urandom);
  endfunction

  function automatic logic [31:0] junk_above(int width);
    if (width >= 32 || $urandom_range(3) != 0) return '0;
    return $urandom << width;
  endfunction

  // Called at a falling edge; returns at a falling edge.
  task automatic send_pixel(input pixel_in_t p);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'(p);
    do @(posedge clk); while (!in_tready);
    pending_pixels.push_back(composite_pixel(p, regs));
    @(negedge clk);
  endtask

  // Drain the pipeline, then write one register.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      rrab_pkg::REG_RECT_WIDTH:    regs.rect_w = val[rrab_pkg::DIM_W-1:0];
      rrab_pkg::REG_RECT_HEIGHT:   regs.rect_h = val[rrab_pkg::DIM_W-1:0];
      rrab_pkg::REG_CORNER_RADIUS: regs.radius = val[rrab_pkg::RAD_W-1:0];
      rrab_pkg::REG_FILL_COLOR:    regs.fill   = val[rrab_pkg::PIX_W-1:0];
      rrab_pkg::REG_BLEND_ALPHA:   regs.alpha  = val[rrab_pkg::CHAN_W-1:0];
      rrab_pkg::REG_SCREEN_WIDTH:  regs.scr_w  = val[rrab_pkg::DIM_W-1:0];
      rrab_pkg::REG_SCREEN_HEIGHT: regs.scr_h  = val[rrab_pkg::DIM_W-1:0];
      default: ;
    endcase
    n_reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_geometry(input int w, input int h, input int rad);
    write_reg(rrab_pkg::REG_RECT_WIDTH, w);
    write_reg(rrab_pkg::REG_RECT_HEIGHT, h);
    write_reg(rrab_pkg::REG_CORNER_RADIUS, rad);
  endtask

  task automatic randomize_regs();
    int w, h, rad, lim;
    case ($urandom_range(9))
      0:       w = 0;
      1:       w = 4095;
      2:       w = $urandom_range(4095);
      default: w = $urandom_range(1, 48);
    endcase
    case ($urandom_range(9))
      0:       h = 0;
      1:       h = 4095;
      2:       h = $urandom_range(4095);
      default: h = $urandom_range(1, 48);
    endcase
    lim = (w > h ? w : h) / 2 + 2;
    if (lim > 2047) lim = 2047;
    case ($urandom_range(9))
      0:       rad = 0;
      1:       rad = 2047;
      2:       rad = $urandom_range(2047);
      default: rad = $urandom_range(lim);
    endcase
    write_reg(rrab_pkg::REG_RECT_WIDTH, w | junk_above(rrab_pkg::DIM_W));
    write_reg(rrab_pkg::REG_RECT_HEIGHT, h | junk_above(rrab_pkg::DIM_W));
    write_reg(rrab_pkg::REG_CORNER_RADIUS, rad | junk_above(rrab_pkg::RAD_W));
    write_reg(rrab_pkg::REG_FILL_COLOR, $urandom);
    case ($urandom_range(7))
      0:       write_reg(rrab_pkg::REG_BLEND_ALPHA, 0);
      1:       write_reg(rrab_pkg::REG_BLEND_ALPHA, 255);
      2:       write_reg(rrab_pkg::REG_BLEND_ALPHA, 1);
      3:       write_reg(rrab_pkg::REG_BLEND_ALPHA, 254);
      default: write_reg(rrab_pkg::REG_BLEND_ALPHA,
                         $urandom_range(255) | junk_above(rrab_pkg::CHAN_W));
    endcase
    case ($urandom_range(9))
      0:       write_reg(rrab_pkg::REG_SCREEN_WIDTH, 4095);
      1:       write_reg(rrab_pkg::REG_SCREEN_WIDTH, 1);
      default: write_reg(rrab_pkg::REG_SCREEN_WIDTH,
                         $urandom_range(1, 80) | junk_above(rrab_pkg::DIM_W));
    endcase
    case ($urandom_range(9))
      0:       write_reg(rrab_pkg::REG_SCREEN_HEIGHT, 4095);
      1:       write_reg(rrab_pkg::REG_SCREEN_HEIGHT, 1);
      default: write_reg(rrab_pkg::REG_SCREEN_HEIGHT,
                         $urandom_range(1, 80) | junk_above(rrab_pkg::DIM_W));
    endcase
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_empty_rect_after_reset();
    send_pixel(mk_pixel(10, 10, 0, 0, 32'h1234_5678));
  endtask

  task automatic test_corner_mask_and_clipping();
    set_geometry(40, 30, 8);
    write_reg(rrab_pkg::REG_FILL_COLOR, 32'h80C0_4020);
    send_pixel(mk_pixel(0, 0, 0, 0, 32'h0000_0000));        // top-left, cut
    send_pixel(mk_pixel(1, 1, 4, 4, 32'hFFFF_FFFF));        // top-left, kept
    send_pixel(mk_pixel(2, 0, 39, 0, 32'h0F0F_0F0F));       // top-right, cut
    send_pixel(mk_pixel(3, 2, 35, 3, 32'hF0F0_F0F0));       // top-right, kept
    send_pixel(mk_pixel(0, 29, 0, 29, 32'hAAAA_AAAA));      // bottom-left, cut
    send_pixel(mk_pixel(4, 5, 2, 25, 32'h5555_5555));       // bottom-left, kept
    send_pixel(mk_pixel(6, 6, 39, 29, 32'h0123_4567));      // bottom-right, cut
    send_pixel(mk_pixel(7, 7, 34, 24, 32'h89AB_CDEF));      // bottom-right, kept
    send_pixel(mk_pixel(9, 9, 40, 5, 32'h1111_1111));       // past right edge
    send_pixel(mk_pixel(9, 9, 5, 30, 32'h2222_2222));       // past bottom edge
    send_pixel(mk_pixel(10, 10, 2047, 2047, 32'h3333_3333));
    send_pixel(mk_pixel(-1, 5, 20, 15, 32'h4444_4444));
    send_pixel(mk_pixel(5, -4096, 20, 15, 32'h6666_6666));
    send_pixel(mk_pixel(1024, 5, 20, 15, 32'h7777_7777));
    send_pixel(mk_pixel(1023, 767, 20, 15, 32'h8888_8888));
    send_pixel(mk_pixel(4095, 4095, 20, 15, 32'h9999_9999));
  endtask

  task automatic test_blend_weights();
    set_geometry(16, 16, 0);
    write_reg(rrab_pkg::REG_FILL_COLOR, 32'hFFFF_FFFF);
    write_reg(rrab_pkg::REG_BLEND_ALPHA, 0);
    send_pixel(mk_pixel(3, 3, 8, 8, 32'h0000_0000));
    write_reg(rrab_pkg::REG_BLEND_ALPHA, 1);
    send_pixel(mk_pixel(3, 3, 8, 8, 32'h0000_0000));
    write_reg(rrab_pkg::REG_BLEND_ALPHA, 128);
    send_pixel(mk_pixel(3, 3, 8, 8, 32'h00FF_8001));
    write_reg(rrab_pkg::REG_FILL_COLOR, 32'h0000_0000);
    write_reg(rrab_pkg::REG_BLEND_ALPHA, 254);
    send_pixel(mk_pixel(3, 3, 8, 8, 32'hFFFF_FFFF));
    write_reg(rrab_pkg::REG_BLEND_ALPHA, 255);
    send_pixel(mk_pixel(3, 3, 0, 0, 32'hFFFF_FFFF));
  endtask

  task automatic test_oversized_radius();
    set_geometry(5, 5, 2047);
    write_reg(rrab_pkg::REG_FILL_COLOR, 32'h00A5_5A00);
    send_pixel(mk_pixel(2, 2, 2, 2, 32'hDEAD_BEEF));
    set_geometry(4095, 4095, 2047);
    write_reg(rrab_pkg::REG_SCREEN_WIDTH, 4095);
    write_reg(rrab_pkg::REG_SCREEN_HEIGHT, 4095);
    send_pixel(mk_pixel(0, 0, 0, 0, 32'hCAFE_F00D));
    send_pixel(mk_pixel(4095, 4095, 2047, 2047, 32'hCAFE_F00D));
  endtask

  task automatic test_zero_screen_and_bad_index();
    set_geometry(16, 16, 4);
    write_reg(rrab_pkg::REG_SCREEN_WIDTH, 0);
    send_pixel(mk_pixel(0, 0, 8, 8, 32'h1357_9BDF));
    write_reg(rrab_pkg::REG_SCREEN_WIDTH, 64);
    write_reg(rrab_pkg::REG_SCREEN_HEIGHT, 64);
    // an index past the register list must change nothing
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send_pixel(mk_pixel(5, 5, 8, 8, 32'h2468_ACE0));
  endtask

  task automatic test_random_traffic();
    int src_pct[4]  = '{0, 87, 0, 33};
    int sink_pct[4] = '{0, 0, 87, 33};
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct   = src_pct[ph];
      sink_stall_pct = sink_pct[ph];
      for (int k = 0; k < 5; k++) begin
        randomize_regs();
        repeat (90) send_pixel(rand_pixel());
      end
    end
  endtask

  task automatic test_output_backpressure();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    set_geometry(24, 24, 6);
    hold_request = 1'b1;
    // keep offering until the pipeline fills and in_tready drops
    repeat (40) send_pixel(rand_pixel());
  endtask

  // ---------------------------------------------------------------- receiver and checker

  initial begin : sink_ready
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : check_results
    pixel_out_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected result: new_pixel=%h write_pixel=%b", out_tdata, out_tuser);
        n_errors++;
      end else begin
        want = pending_pixels.pop_front();
        n_checked++;
        if (want.write_pixel) n_drawn++;
        if (out_tdata !== want.new_pixel) begin
          $error("new_pixel: expected %h, got %h", want.new_pixel, out_tdata);
          n_errors++;
        end
        if (out_tuser[0] !== want.write_pixel) begin
          $error("write_pixel: expected %b, got %b", want.write_pixel, out_tuser[0]);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_empty_rect_after_reset();
    test_corner_mask_and_clipping();
    test_blend_weights();
    test_oversized_radius();
    test_zero_screen_and_bad_index();
    test_random_traffic();
    test_output_backpressure();
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    $display("summary: %0d pixels checked, %0d drawn inside the mask, %0d register writes",
             n_checked, n_drawn, n_reg_writes);
    $display("summary: four idle/stall mixes plus one long output hold-off");
    if (n_errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
